// ----- rtl/core/rbsf_pkg.sv -----
package rbsf_pkg;

    // Frame geometry
    localparam int MAX_SIDE   = 1024;
    localparam int ADDR_W     = $clog2(MAX_SIDE);
    localparam int POS_W      = ADDR_W + 1;
    localparam int SIDE_MIN   = 3;
    localparam int SIDE_RESET = 512;

    // Pixel and result field widths
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int PIX_W   = NUM_CH * CH_W;
    localparam int COORD_W = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Arithmetic: the sum of nine channel values needs 12 bits.
    localparam int SUM_W      = 12;
    localparam int DIFF_W     = SUM_W + 2;
    localparam int DIV9_SHIFT = 16;
    localparam int DIV9_MUL   = (1 << DIV9_SHIFT) / 9 + 1;
    localparam int PROD_W     = SUM_W + DIV9_SHIFT;
    localparam int CH_MAX     = (1 << CH_W) - 1;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_MODE = 1'b0,
        CFG_IMAGE_SIDE  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        MODE_BLUR    = 1'b0,
        MODE_SHARPEN = 1'b1
    } filter_mode_t;

    // One channel of the filter. The division by nine is a multiplication by a
    // rounded-up reciprocal; its error stays well below one ninth over the
    // whole range of the sum, so the truncated quotient is exact.
    function automatic logic [CH_W-1:0] filter_channel(
        input logic [SUM_W-1:0] sum,
        input logic [CH_W-1:0]  centre,
        input filter_mode_t     mode
    );
        logic [PROD_W-1:0]        prod;
        logic [DIFF_W-1:0]        ten_centre;
        logic signed [DIFF_W-1:0] diff;
        logic [CH_W-1:0]          res;
        prod       = PROD_W'(sum) * PROD_W'(DIV9_MUL);
        ten_centre = DIFF_W'({centre, 3'b000}) + DIFF_W'({centre, 1'b0});
        diff       = signed'(ten_centre) - signed'(DIFF_W'(sum));
        if (mode == MODE_BLUR) begin
            res = prod[DIV9_SHIFT +: CH_W];
        end else if (diff < 0) begin
            res = '0;
        end else if (diff > DIFF_W'(CH_MAX)) begin
            res = CH_W'(CH_MAX);
        end else begin
            res = diff[CH_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/rbsf_if.sv -----
interface rbsf_pix_if import rbsf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            frame_start;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output frame_start, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input frame_start, output ready);
endinterface

interface rbsf_res_if import rbsf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    red_out;
    logic [CH_W-1:0]    green_out;
    logic [CH_W-1:0]    blue_out;
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output pixel_column, output pixel_row, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input pixel_column, input pixel_row, output ready);
endinterface

// ----- rtl/core/rgb_3x3_blur_sharpen_filter.sv -----
// 3x3 box blur or Laplacian sharpen over a square RGB frame streamed in raster
// order, one pixel per beat, and one pixel per clock sustained: a new beat is
// taken in every cycle unless a finished result is waiting for its output beat.
// Each channel is filtered on its own; blur gives the 3x3 sum divided by nine,
// truncated, and sharpen gives nine times the centre minus the eight
// neighbours, clamped to 0..255. Only interior pixels produce a result beat,
// which carries the centre's column and row and reaches the output register
// as the pixel one row and one column further on leaves the first stage.
// Border pixels produce no beat. frame_start on a beat restarts the position at
// row 0, column 0; without it the position wraps after the last pixel of the
// frame. The side is clamped to 3..1024 when written. The two previous rows
// live in a single line store of 1024 words by 48 bits with one write and one
// registered read per clock; it has no reset and needs no clearing pass, since
// every entry that feeds a result in a frame of constant side was written by an
// earlier row. Configuration may be written only while no beat is in flight.
module rgb_3x3_blur_sharpen_filter
    import rbsf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rbsf_pix_if.sink              pixel,
    rbsf_res_if.source            result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers. The side is stored already clamped.
    filter_mode_t     mode_reg;
    logic [POS_W-1:0] side_reg;
    logic [POS_W-1:0] side_next;

    always_comb begin
        if (cfg_data < CFG_DATA_W'(SIDE_MIN)) begin
            side_next = POS_W'(SIDE_MIN);
        end else if (cfg_data > CFG_DATA_W'(MAX_SIDE)) begin
            side_next = POS_W'(MAX_SIDE);
        end else begin
            side_next = POS_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg <= MODE_BLUR;
            side_reg <= POS_W'(SIDE_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FILTER_MODE: mode_reg <= filter_mode_t'(cfg_data[0]);
                CFG_IMAGE_SIDE:  side_reg <= side_next;
            endcase
        end
    end

    // Handshake and stage control. The first stage holds the accepted pixel
    // alongside the line store's registered read; it moves on whenever the
    // output register is empty or being emptied in the same cycle.
    logic pix_acc;
    logic s1_valid_reg;
    logic s1_move;
    logic res_valid_reg;

    assign s1_move     = s1_valid_reg && (!res_valid_reg || result.ready);
    assign pixel.ready = !s1_valid_reg || s1_move;
    assign pix_acc     = pixel.valid && pixel.ready;

    // Position of the arriving pixel. The stored counters point at the next
    // pixel; they are corrected first for frame_start and for a side that has
    // shrunk below them, then advanced past this pixel.
    logic [ADDR_W-1:0] col_cnt_reg, row_cnt_reg;
    logic [ADDR_W-1:0] col_cnt_next, row_cnt_next;
    logic [ADDR_W-1:0] col_base, row_base;
    logic [ADDR_W-1:0] col_pos, row_pos;
    logic [POS_W-1:0]  row_tmp, col_inc, row_inc;
    logic              pos_emit;

    always_comb begin
        col_base = pixel.frame_start ? '0 : col_cnt_reg;
        row_base = pixel.frame_start ? '0 : row_cnt_reg;

        if ({1'b0, col_base} >= side_reg) begin
            col_pos = '0;
            row_tmp = {1'b0, row_base} + POS_W'(1);
        end else begin
            col_pos = col_base;
            row_tmp = {1'b0, row_base};
        end
        row_pos = (row_tmp >= side_reg) ? '0 : row_tmp[ADDR_W-1:0];

        col_inc = {1'b0, col_pos} + POS_W'(1);
        row_inc = {1'b0, row_pos} + POS_W'(1);
        if (col_inc >= side_reg) begin
            col_cnt_next = '0;
            row_cnt_next = (row_inc >= side_reg) ? '0 : row_inc[ADDR_W-1:0];
        end else begin
            col_cnt_next = col_inc[ADDR_W-1:0];
            row_cnt_next = row_pos;
        end

        // The window is complete once two rows and two columns lie behind.
        pos_emit = (row_pos >= ADDR_W'(2)) && (col_pos >= ADDR_W'(2));
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (pix_acc) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Line store: each word holds the pixel two rows up in its upper half and
    // the pixel one row up in its lower half, for one column.
    logic [2*PIX_W-1:0] line_mem [MAX_SIDE];
    logic [2*PIX_W-1:0] line_rd_reg;
    logic [2*PIX_W-1:0] line_word;
    logic [2*PIX_W-1:0] line_wr_data;

    // First stage registers
    pixel_t             s1_px_reg;
    logic [ADDR_W-1:0]  s1_col_reg, s1_row_reg;
    logic               s1_emit_reg;
    logic               byp_hit_reg;
    logic [2*PIX_W-1:0] byp_data_reg;
    pixel_t             line_top, line_mid;

    // The read for a new pixel is taken at the same edge as the write of the
    // pixel ahead of it, so it sees the old word. That only matters when both
    // fall on the same column (frame_start on two beats in a row); the word
    // being written is then captured and used in place of the read.
    assign line_word    = byp_hit_reg ? byp_data_reg : line_rd_reg;
    assign line_top     = line_word[2*PIX_W-1:PIX_W];
    assign line_mid     = line_word[PIX_W-1:0];
    assign line_wr_data = {line_mid, s1_px_reg};

    always_ff @(posedge clk) begin
        if (s1_move) begin
            line_mem[s1_col_reg] <= line_wr_data;
        end
        if (pix_acc) begin
            line_rd_reg <= line_mem[col_pos];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (pix_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (pix_acc) begin
            s1_px_reg    <= {pixel.blue_in, pixel.green_in, pixel.red_in};
            s1_col_reg   <= col_pos;
            s1_row_reg   <= row_pos;
            s1_emit_reg  <= pos_emit;
            byp_hit_reg  <= s1_move && (s1_col_reg == col_pos);
            byp_data_reg <= line_wr_data;
        end
    end

    // Window of the two previous columns: entries 0..2 are the older column
    // (top, middle, bottom), entries 3..5 the newer one. It shifts once for
    // every pixel that leaves the first stage.
    pixel_t win_reg [6];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_move) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= line_top;
            win_reg[4] <= line_mid;
            win_reg[5] <= s1_px_reg;
        end
    end

    // Filter: a nine-input sum per channel, then divide or sharpen and clamp.
    // The centre of the window is the middle of the newer stored column.
    pixel_t             filt_px;
    logic [SUM_W-1:0]   ch_sum;

    always_comb begin
        filt_px = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            ch_sum = SUM_W'(win_reg[0][k*CH_W +: CH_W])
                   + SUM_W'(win_reg[1][k*CH_W +: CH_W])
                   + SUM_W'(win_reg[2][k*CH_W +: CH_W])
                   + SUM_W'(win_reg[3][k*CH_W +: CH_W])
                   + SUM_W'(win_reg[4][k*CH_W +: CH_W])
                   + SUM_W'(win_reg[5][k*CH_W +: CH_W])
                   + SUM_W'(line_top[k*CH_W +: CH_W])
                   + SUM_W'(line_mid[k*CH_W +: CH_W])
                   + SUM_W'(s1_px_reg[k*CH_W +: CH_W]);
            filt_px[k*CH_W +: CH_W] = filter_channel(ch_sum, win_reg[4][k*CH_W +: CH_W],
                                                     mode_reg);
        end
    end

    // Output register. The centre sits one column and one row behind the
    // pixel that completed its window.
    pixel_t             res_px_reg;
    logic [COORD_W-1:0] res_col_reg, res_row_reg;
    logic [ADDR_W-1:0]  centre_col, centre_row;

    assign centre_col = s1_col_reg - ADDR_W'(1);
    assign centre_row = s1_row_reg - ADDR_W'(1);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (s1_move) begin
            res_valid_reg <= s1_emit_reg;
        end else if (result.ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_move && s1_emit_reg) begin
            res_px_reg  <= filt_px;
            res_col_reg <= COORD_W'(centre_col);
            res_row_reg <= COORD_W'(centre_row);
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.red_out      = res_px_reg[0*CH_W +: CH_W];
    assign result.green_out    = res_px_reg[1*CH_W +: CH_W];
    assign result.blue_out     = res_px_reg[2*CH_W +: CH_W];
    assign result.pixel_column = res_col_reg;
    assign result.pixel_row    = res_row_reg;

`ifndef SYNTHESIS
    // A pixel that leaves the first stage with a complete window lands in the
    // output register.
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_emit_reg) |=> res_valid_reg)
        else $error("filtered pixel did not reach the output register");

    // A pixel held in the first stage keeps its column, so the line store
    // write and the bypass compare see the same address.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move && !pix_acc) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("first stage changed while stalled");

    // A reported centre lies strictly inside the frame.
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_col_reg != '0 && res_row_reg != '0
                           && (POS_W'(res_col_reg) + POS_W'(2)) <= side_reg))
        else $error("result centre outside the interior");
`endif

endmodule
